// ===== rtl/core/gbt_pkg.sv =====
// shared types, constants and helpers of the transposed gemm block
`timescale 1ns / 1ps

package gbt_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int DIM_W           = 4;
   localparam int IDX_W           = 3;
   localparam int VAL_W           = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int ELEM_W          = 7;
   localparam int MUL_W           = 18;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int SUM_W           = 35;
   localparam int ACC_W           = 51;
   localparam int SUM_LO_W        = 17;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_LOAD_C = 2'd2,
      CMD_RUN    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_M     = 3'd0,
      CSR_COLS_N     = 3'd1,
      CSR_INNER_K    = 3'd2,
      CSR_ALPHA_GAIN = 3'd3,
      CSR_BETA_GAIN  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_ACC,
      ST_ALO,
      ST_AHI,
      ST_BETA,
      ST_BADD,
      ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_AB,
      MOP_ALO,
      MOP_AHI,
      MOP_BC
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic       sum_clr;
      logic       sum_add;
      logic       acc_clr;
      logic       acc_add;
   } mac_ctrl_type;

   // flat store index of element (r, c) with a row pitch of dim
   function automatic logic [ELEM_W-1:0] elem_index(logic [IDX_W-1:0] r,
                                                   logic [IDX_W-1:0] c,
                                                   logic [DIM_W-1:0] dim);
      return ELEM_W'(r) * ELEM_W'(dim) + ELEM_W'(c);
   endfunction

endpackage

// ===== rtl/core/gbt_req_if.sv =====
// command channel: element loads and run requests
`timescale 1ns / 1ps

interface gbt_req_if;
   import gbt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [IDX_W-1:0]        row;
   logic [IDX_W-1:0]        col;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, command, row, col, value, input ready);
   modport sink (input valid, command, row, col, value, output ready);
endinterface

// ===== rtl/core/gbt_rsp_if.sv =====
// result channel: one beat per emitted C element
`timescale 1ns / 1ps

interface gbt_rsp_if;
   import gbt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [VAL_W-1:0] out_value;
   logic                    last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// ===== rtl/core/gbt_store.sv =====
// single-port-write, registered-read element store
`timescale 1ns / 1ps

module gbt_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gbt_mac.sv =====
// shared 18x18 multiplier with the inner-product and output accumulators
`timescale 1ns / 1ps

module gbt_mac (
   input  logic                             clock,
   input  gbt_pkg::mac_ctrl_type            ctrl,
   input  logic signed [gbt_pkg::VAL_W-1:0] a_val,
   input  logic signed [gbt_pkg::VAL_W-1:0] b_val,
   input  logic signed [gbt_pkg::VAL_W-1:0] c_val,
   input  logic signed [gbt_pkg::VAL_W-1:0] alpha,
   input  logic signed [gbt_pkg::VAL_W-1:0] beta,
   output logic signed [gbt_pkg::VAL_W-1:0] result
);
   import gbt_pkg::*;

   typedef enum logic [1:0] {
      SH_0,
      SH_8,
      SH_17
   } shift_type;

   logic signed [MUL_W-1:0]  x;
   logic signed [MUL_W-1:0]  y;
   logic signed [PROD_W-1:0] prod;
   shift_type                shift_in;
   logic signed [PROD_W-1:0] p_ff;
   shift_type                shift_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  addend;
   logic signed [SUM_W-1:0]  scaled;
   logic                     in_range;

   always_comb begin
      x        = '0;
      y        = '0;
      shift_in = SH_0;
      case (ctrl.op)
         MOP_AB: begin
            x = MUL_W'(a_val);
            y = MUL_W'(b_val);
         end
         // alpha times the low 17 bits of the sum, taken as unsigned
         MOP_ALO: begin
            x = MUL_W'(alpha);
            y = $signed({1'b0, sum_ff[SUM_LO_W-1:0]});
         end
         MOP_AHI: begin
            x        = MUL_W'(alpha);
            y        = sum_ff[SUM_W-1:SUM_LO_W];
            shift_in = SH_17;
         end
         MOP_BC: begin
            x        = MUL_W'(beta);
            y        = MUL_W'(c_val);
            shift_in = SH_8;
         end
         default: begin
            x = '0;
            y = '0;
         end
      endcase
   end

   assign prod = x * y;

   always_ff @(posedge clock) begin
      if (ctrl.op != MOP_NONE) begin
         p_ff     <= prod;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      case (shift_ff)
         SH_8:    addend = ACC_W'(p_ff) <<< 8;
         SH_17:   addend = ACC_W'(p_ff) <<< SUM_LO_W;
         default: addend = ACC_W'(p_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_clr) begin
         sum_ff <= '0;
      end else if (ctrl.sum_add) begin
         sum_ff <= sum_ff + SUM_W'(p_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_clr) begin
         acc_ff <= '0;
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + addend;
      end
   end

   // floor shift by 16, then clamp to 16 bits
   assign scaled   = acc_ff[ACC_W-1:16];
   assign in_range = (scaled[SUM_W-1:VAL_W-1] == '0) || (scaled[SUM_W-1:VAL_W-1] == '1);
   assign result   = in_range ? scaled[VAL_W-1:0]
                   : (scaled[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}});

endmodule

// ===== rtl/core/gbt_seq.sv =====
// sequencer: walks the C elements and the inner dimension, drives the mac
`timescale 1ns / 1ps

module gbt_seq #(
   parameter int MAX_DIM = gbt_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W  = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_fire,
   input  logic [1:0]                   req_command,
   input  logic [gbt_pkg::DIM_W-1:0]    rows_m,
   input  logic [gbt_pkg::DIM_W-1:0]    cols_n,
   input  logic [gbt_pkg::DIM_W-1:0]    inner_k,
   input  logic                         out_free,
   output logic                         req_ready,
   output gbt_pkg::mac_ctrl_type        mac_ctrl,
   output logic [ADDR_W-1:0]            a_addr,
   output logic [ADDR_W-1:0]            b_addr,
   output logic [ADDR_W-1:0]            c_addr,
   output logic                         emit,
   output logic [gbt_pkg::IDX_W-1:0]    emit_row,
   output logic [gbt_pkg::IDX_W-1:0]    emit_col,
   output logic                         emit_last
);
   import gbt_pkg::*;

   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [DIM_W-1:0] PITCH = DIM_W'(MAX_DIM);

   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [CNT_W-1:0] i_ff;
   logic [CNT_W-1:0] i_in;
   logic [CNT_W-1:0] j_ff;
   logic [CNT_W-1:0] j_in;
   logic [CNT_W-1:0] l_ff;
   logic [CNT_W-1:0] l_in;
   logic             run_go;
   logic             last_i;
   logic             last_j;
   logic             last_l;

   assign run_go = req_fire && (req_command == CMD_RUN) && (rows_m != '0) && (cols_n != '0);
   assign last_i = (DIM_W'(i_ff) + DIM_W'(1)) == rows_m;
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1)) == cols_n;
   assign last_l = (DIM_W'(l_ff) + DIM_W'(1)) == inner_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      l_ff <= l_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (run_go) state_in = ST_START;
         ST_START: state_in = (inner_k == '0) ? ST_ALO : ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = last_l ? ST_ALO : ST_MUL;
         ST_ALO:   state_in = ST_AHI;
         ST_AHI:   state_in = ST_BETA;
         ST_BETA:  state_in = ST_BADD;
         ST_BADD:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = (last_i && last_j) ? ST_IDLE : ST_START;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // counters; store reads are addressed from the next values so data lines up
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      l_in = l_ff;
      if (state_ff == ST_IDLE && run_go) begin
         i_in = '0;
         j_in = '0;
         l_in = '0;
      end else if (state_ff == ST_ACC && !last_l) begin
         l_in = l_ff + CNT_W'(1);
      end else if (state_ff == ST_OUT && out_free) begin
         l_in = '0;
         if (last_i) begin
            i_in = '0;
            j_in = j_ff + CNT_W'(1);
         end else begin
            i_in = i_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      mac_ctrl = '{op: MOP_NONE, sum_clr: 1'b0, sum_add: 1'b0, acc_clr: 1'b0, acc_add: 1'b0};
      req_ready = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_START: begin
            mac_ctrl.sum_clr = 1'b1;
            mac_ctrl.acc_clr = 1'b1;
         end
         ST_MUL:   mac_ctrl.op = MOP_AB;
         ST_ACC:   mac_ctrl.sum_add = 1'b1;
         ST_ALO:   mac_ctrl.op = MOP_ALO;
         ST_AHI: begin
            mac_ctrl.op      = MOP_AHI;
            mac_ctrl.acc_add = 1'b1;
         end
         ST_BETA: begin
            mac_ctrl.op      = MOP_BC;
            mac_ctrl.acc_add = 1'b1;
         end
         ST_BADD:  mac_ctrl.acc_add = 1'b1;
         ST_OUT:   emit = out_free;
         default:  req_ready = 1'b0;
      endcase
   end

   // A is addressed [l][i], B is [j][l], C is [i][j]
   assign a_addr = ADDR_W'(elem_index(IDX_W'(l_in), IDX_W'(i_in), PITCH));
   assign b_addr = ADDR_W'(elem_index(IDX_W'(j_in), IDX_W'(l_in), PITCH));
   assign c_addr = ADDR_W'(elem_index(IDX_W'(i_in), IDX_W'(j_in), PITCH));

   assign emit_row  = IDX_W'(i_ff);
   assign emit_col  = IDX_W'(j_ff);
   assign emit_last = last_i && last_j;

endmodule

// ===== rtl/core/gemm_both_transposed_unit.sv =====
// Computes C = alpha * A' * B' + beta * C on signed Q8.8 elements. A load beat
// (load A, B or C) writes one element and leaves the command port ready. A run
// beat walks C column by column and emits each new element, also writing it
// back into C. Each element clears the sums, takes a multiply and an add per
// inner index (inner_k of them), then alpha*sum in two halves and beta*c, and
// waits at the output while the result port is full. The single 18x18 multiplier
// serves every A*B product, the two halves of alpha*sum and beta*c in turn.
// The command port is not ready while a run is in progress; the last result
// may still wait at the output while new loads are accepted.
`timescale 1ns / 1ps

module gemm_both_transposed_unit #(
   parameter int MAX_DIM = gbt_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   gbt_req_if.sink                           req_chan,
   gbt_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [gbt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gbt_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [DIM_W-1:0] PITCH = DIM_W'(MAX_DIM);

   logic [DIM_W-1:0]        rows_m_ff;
   logic [DIM_W-1:0]        cols_n_ff;
   logic [DIM_W-1:0]        inner_k_ff;
   logic signed [VAL_W-1:0] alpha_gain_ff;
   logic signed [VAL_W-1:0] beta_gain_ff;
   logic [DIM_W-1:0]        dim_wdata;

   logic                    req_ready;
   logic                    req_fire;
   logic                    load_ok;
   logic                    wr_a;
   logic                    wr_b;
   logic                    wr_c;
   logic [ADDR_W-1:0]       load_addr;
   logic [ADDR_W-1:0]       c_wr_addr;
   logic [VAL_W-1:0]        c_wr_data;

   mac_ctrl_type            mac_ctrl;
   logic [ADDR_W-1:0]       a_addr;
   logic [ADDR_W-1:0]       b_addr;
   logic [ADDR_W-1:0]       c_addr;
   logic [VAL_W-1:0]        a_rd;
   logic [VAL_W-1:0]        b_rd;
   logic [VAL_W-1:0]        c_rd;
   logic signed [VAL_W-1:0] mac_result;
   logic                    emit;
   logic [IDX_W-1:0]        emit_row;
   logic [IDX_W-1:0]        emit_col;
   logic                    emit_last;
   logic                    out_free;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [IDX_W-1:0]        rsp_row_ff;
   logic [IDX_W-1:0]        rsp_col_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_last_ff;

   // ---------------- configuration registers ----------------
   assign dim_wdata = (csr_wdata[DIM_W-1:0] > PITCH) ? PITCH : csr_wdata[DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff     <= '0;
         cols_n_ff     <= '0;
         inner_k_ff    <= '0;
         alpha_gain_ff <= VAL_W'(256);
         beta_gain_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_M:     rows_m_ff     <= dim_wdata;
            CSR_COLS_N:     cols_n_ff     <= dim_wdata;
            CSR_INNER_K:    inner_k_ff    <= dim_wdata;
            CSR_ALPHA_GAIN: alpha_gain_ff <= csr_wdata;
            CSR_BETA_GAIN:  beta_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- element loads ----------------
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;
   assign load_ok        = req_fire && (DIM_W'(req_chan.row) < PITCH)
                                    && (DIM_W'(req_chan.col) < PITCH);
   assign load_addr      = ADDR_W'(elem_index(req_chan.row, req_chan.col, PITCH));

   always_comb begin
      wr_a = 1'b0;
      wr_b = 1'b0;
      wr_c = 1'b0;
      if (load_ok) begin
         case (req_chan.command)
            CMD_LOAD_A: wr_a = 1'b1;
            CMD_LOAD_B: wr_b = 1'b1;
            CMD_LOAD_C: wr_c = 1'b1;
            default: ;
         endcase
      end
   end

   // write-back of a finished element shares the C write port with loads
   assign c_wr_addr = emit ? ADDR_W'(elem_index(emit_row, emit_col, PITCH)) : load_addr;
   assign c_wr_data = emit ? mac_result : req_chan.value;

   gbt_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_a_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (load_addr),
      .wr_data (req_chan.value),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   gbt_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_b_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (load_addr),
      .wr_data (req_chan.value),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   gbt_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_c_store (
      .clock   (clock),
      .wr_en   (wr_c || emit),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_addr),
      .rd_data (c_rd)
   );

   // ---------------- sequencer and arithmetic ----------------
   gbt_seq #(.MAX_DIM(MAX_DIM), .ADDR_W(ADDR_W)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_command (req_chan.command),
      .rows_m      (rows_m_ff),
      .cols_n      (cols_n_ff),
      .inner_k     (inner_k_ff),
      .out_free    (out_free),
      .req_ready   (req_ready),
      .mac_ctrl    (mac_ctrl),
      .a_addr      (a_addr),
      .b_addr      (b_addr),
      .c_addr      (c_addr),
      .emit        (emit),
      .emit_row    (emit_row),
      .emit_col    (emit_col),
      .emit_last   (emit_last)
   );

   gbt_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .a_val  (a_rd),
      .b_val  (b_rd),
      .c_val  (c_rd),
      .alpha  (alpha_gain_ff),
      .beta   (beta_gain_ff),
      .result (mac_result)
   );

   // ---------------- result register ----------------
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= emit_row;
         rsp_col_ff   <= emit_col;
         rsp_value_ff <= mac_result;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

// ===== rtl/core/gbt_checker.sv =====
// port-level checks of the transposed gemm block, bound to the top level
`timescale 1ns / 1ps

module gbt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gbt_pkg::VAL_W-1:0]     rsp_out_value,
   input logic                          rsp_last
);
   import gbt_pkg::*;

   // a load beat never stalls the command port
   property load_keeps_ready;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready && req_command != CMD_RUN) |=> req_ready;
   endproperty
   a_load_keeps_ready: assert property (load_keeps_ready)
      else $error("command port not ready after a load beat");

   // while a run still has elements to emit, no new command is taken
   property busy_while_run_open;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_last) |-> !req_ready;
   endproperty
   a_busy_while_run_open: assert property (busy_while_run_open)
      else $error("command port ready in the middle of a run");

   // a stalled beat keeps its last flag
   property last_holds;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> $stable(rsp_last);
   endproperty
   a_last_holds: assert property (last_holds)
      else $error("last flag of a stalled result beat changed");

   property rsp_holds;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_value));
   endproperty
   a_rsp_holds: assert property (rsp_holds)
      else $error("stalled result beat changed or dropped");

endmodule

bind gemm_both_transposed_unit gbt_checker u_gbt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_command   (req_chan.command),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_value (rsp_chan.out_value),
   .rsp_last      (rsp_chan.last)
);
